@@ hdl/ialu_pkg.sv @@
// Shared types and constants for the integer ALU with GCD.
// Used by the sequencer, the datapath, the top level and the checker.
// Depends on nothing.
package ialu_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int CMD_W          = 3;
    localparam int ORDER_W        = 2;
    localparam int STATUS_W       = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_CMP = 3'd4,
        CMD_GCD = 3'd5
    } t_cmd;

    typedef enum logic [ORDER_W-1:0] {
        ORD_LESS    = 2'd0,
        ORD_EQUAL   = 2'd1,
        ORD_GREATER = 2'd2
    } t_order;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_GCD_ZERO = 2'd2,
        ST_INVALID  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_ABS_A,
        S_ABS_B,
        S_DIV,
        S_DIV_END,
        S_DONE
    } t_state;

    // Operation applied by the datapath in the current cycle.
    typedef enum logic [3:0] {
        DP_HOLD,
        DP_LOAD,
        DP_ADD,
        DP_SUB,
        DP_CMP,
        DP_CLEAR,
        DP_MUL_INIT,
        DP_MUL_STEP,
        DP_ABS_A,
        DP_ABS_B,
        DP_DIV_STEP,
        DP_SIGN_FIX,
        DP_GCD_NEXT,
        DP_GCD_DONE
    } t_dp_op;

    typedef struct packed {
        logic a_zero;
        logic b_zero;
        logic rem_zero;
        logic cnt_last;
        logic cmp_lt;
        logic cmp_eq;
    } t_dp_stat;

endpackage

@@ hdl/ialu_dp.sv @@
// Datapath of the integer ALU: operand registers, step counter and the one
// shared add/subtract unit used by every operation. Depends on ialu_pkg.
module ialu_dp #(
    parameter int DATA_WIDTH = ialu_pkg::DATA_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  ialu_pkg::t_dp_op         i_op,
    input  logic [DATA_WIDTH-1:0]    i_a,
    input  logic [DATA_WIDTH-1:0]    i_b,
    output ialu_pkg::t_dp_stat       o_stat,
    output logic [DATA_WIDTH-1:0]    o_result
);

    localparam int W  = DATA_WIDTH;
    localparam int CW = $clog2(DATA_WIDTH);

    logic [W-1:0]  r_a, n_a;     // operand a, accumulator, remainder, result
    logic [W-1:0]  r_b, n_b;     // operand b, multiplicand, divisor
    logic [W-1:0]  r_q, n_q;     // multiplier, dividend, quotient
    logic          r_neg, n_neg; // quotient sign
    logic [CW-1:0] r_cnt, n_cnt;

    logic [W:0]    add_x, add_y, add_sum;
    logic          add_inv;
    logic          div_fit;

    // Shared adder: x + y, or x - y when add_inv is set.
    always_comb begin
        add_x   = '0;
        add_y   = '0;
        add_inv = 1'b0;
        case (i_op)
            ialu_pkg::DP_ADD: begin
                add_x = {r_a[W-1], r_a};
                add_y = {r_b[W-1], r_b};
            end
            ialu_pkg::DP_SUB, ialu_pkg::DP_CMP: begin
                add_x   = {r_a[W-1], r_a};
                add_y   = {r_b[W-1], r_b};
                add_inv = 1'b1;
            end
            ialu_pkg::DP_MUL_STEP: begin
                add_x = {1'b0, r_a[W-2:0], 1'b0};
                add_y = r_q[W-1] ? {1'b0, r_b} : '0;
            end
            ialu_pkg::DP_ABS_A: begin
                add_y   = {1'b0, r_a};
                add_inv = r_a[W-1];
            end
            ialu_pkg::DP_ABS_B: begin
                add_y   = {1'b0, r_b};
                add_inv = r_b[W-1];
            end
            ialu_pkg::DP_DIV_STEP: begin
                add_x   = {r_a, r_q[W-1]};
                add_y   = {1'b0, r_b};
                add_inv = 1'b1;
            end
            ialu_pkg::DP_SIGN_FIX: begin
                add_y   = {1'b0, r_q};
                add_inv = r_neg;
            end
            default: begin
                add_x   = '0;
            end
        endcase
        add_sum = add_x + (add_y ^ {(W+1){add_inv}}) + {{W{1'b0}}, add_inv};
    end

    assign div_fit = ~add_sum[W];

    always_comb begin
        n_a   = r_a;
        n_b   = r_b;
        n_q   = r_q;
        n_neg = r_neg;
        n_cnt = '0;
        case (i_op)
            ialu_pkg::DP_LOAD: begin
                n_a   = i_a;
                n_b   = i_b;
                n_neg = i_a[W-1] ^ i_b[W-1];
            end
            ialu_pkg::DP_ADD, ialu_pkg::DP_SUB, ialu_pkg::DP_MUL_STEP,
            ialu_pkg::DP_SIGN_FIX: begin
                n_a = add_sum[W-1:0];
                if (i_op == ialu_pkg::DP_MUL_STEP) begin
                    n_q   = {r_q[W-2:0], 1'b0};
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ialu_pkg::DP_CMP, ialu_pkg::DP_CLEAR: begin
                n_a = '0;
            end
            ialu_pkg::DP_MUL_INIT: begin
                n_q = r_a;
                n_a = '0;
            end
            ialu_pkg::DP_ABS_A: begin
                n_q = add_sum[W-1:0];
            end
            ialu_pkg::DP_ABS_B: begin
                n_b = add_sum[W-1:0];
                n_a = '0;
            end
            ialu_pkg::DP_DIV_STEP: begin
                n_a   = div_fit ? add_sum[W-1:0] : add_x[W-1:0];
                n_q   = {r_q[W-2:0], div_fit};
                n_cnt = r_cnt + 1'b1;
            end
            ialu_pkg::DP_GCD_NEXT: begin
                n_q = r_b;
                n_b = r_a;
                n_a = '0;
            end
            ialu_pkg::DP_GCD_DONE: begin
                n_a = r_b;
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_a   <= n_a;
        r_b   <= n_b;
        r_q   <= n_q;
        r_neg <= n_neg;
    end

    assign o_stat.a_zero   = (r_a == '0);
    assign o_stat.b_zero   = (r_b == '0);
    assign o_stat.rem_zero = (r_a == '0);
    assign o_stat.cnt_last = (r_cnt == CW'(W - 1));
    assign o_stat.cmp_lt   = add_sum[W];
    assign o_stat.cmp_eq   = (add_sum == '0);
    assign o_result        = r_a;

endmodule

@@ hdl/ialu_seq.sv @@
// Sequencer of the integer ALU: picks the datapath operation for each cycle
// and sets order and status. Depends on ialu_pkg.
module ialu_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  ialu_pkg::t_cmd      i_cmd,
    input  logic                i_take,
    input  ialu_pkg::t_dp_stat  i_stat,
    output ialu_pkg::t_dp_op    o_op,
    output logic                o_idle,
    output logic                o_done,
    output ialu_pkg::t_order    o_order,
    output ialu_pkg::t_status   o_status
);

    ialu_pkg::t_state  r_state, n_state;
    ialu_pkg::t_cmd    r_cmd, n_cmd;
    ialu_pkg::t_order  r_order, n_order;
    ialu_pkg::t_status r_status, n_status;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ialu_pkg::S_IDLE: begin
                if (i_start) n_state = ialu_pkg::S_EXEC;
            end
            ialu_pkg::S_EXEC: begin
                case (r_cmd)
                    ialu_pkg::CMD_MUL: n_state = ialu_pkg::S_MUL;
                    ialu_pkg::CMD_DIV: begin
                        n_state = i_stat.b_zero ? ialu_pkg::S_DONE : ialu_pkg::S_ABS_A;
                    end
                    ialu_pkg::CMD_GCD: begin
                        n_state = (i_stat.a_zero || i_stat.b_zero) ?
                                  ialu_pkg::S_DONE : ialu_pkg::S_ABS_A;
                    end
                    default: n_state = ialu_pkg::S_DONE;
                endcase
            end
            ialu_pkg::S_MUL: begin
                if (i_stat.cnt_last) n_state = ialu_pkg::S_DONE;
            end
            ialu_pkg::S_ABS_A: n_state = ialu_pkg::S_ABS_B;
            ialu_pkg::S_ABS_B: n_state = ialu_pkg::S_DIV;
            ialu_pkg::S_DIV: begin
                if (i_stat.cnt_last) n_state = ialu_pkg::S_DIV_END;
            end
            ialu_pkg::S_DIV_END: begin
                if (r_cmd == ialu_pkg::CMD_GCD && !i_stat.rem_zero) begin
                    n_state = ialu_pkg::S_DIV;
                end else begin
                    n_state = ialu_pkg::S_DONE;
                end
            end
            ialu_pkg::S_DONE: begin
                if (i_take) n_state = ialu_pkg::S_IDLE;
            end
            default: n_state = ialu_pkg::S_IDLE;
        endcase
    end

    // Outputs and result codes
    always_comb begin
        o_op     = ialu_pkg::DP_HOLD;
        n_cmd    = r_cmd;
        n_order  = r_order;
        n_status = r_status;
        case (r_state)
            ialu_pkg::S_IDLE: begin
                if (i_start) begin
                    o_op     = ialu_pkg::DP_LOAD;
                    n_cmd    = i_cmd;
                    n_order  = ialu_pkg::ORD_LESS;
                    n_status = ialu_pkg::ST_OK;
                end
            end
            ialu_pkg::S_EXEC: begin
                case (r_cmd)
                    ialu_pkg::CMD_ADD: o_op = ialu_pkg::DP_ADD;
                    ialu_pkg::CMD_SUB: o_op = ialu_pkg::DP_SUB;
                    ialu_pkg::CMD_MUL: o_op = ialu_pkg::DP_MUL_INIT;
                    ialu_pkg::CMD_CMP: begin
                        o_op    = ialu_pkg::DP_CMP;
                        n_order = i_stat.cmp_lt ? ialu_pkg::ORD_LESS :
                                  i_stat.cmp_eq ? ialu_pkg::ORD_EQUAL :
                                                  ialu_pkg::ORD_GREATER;
                    end
                    ialu_pkg::CMD_DIV: begin
                        if (i_stat.b_zero) begin
                            o_op     = ialu_pkg::DP_CLEAR;
                            n_status = ialu_pkg::ST_DIV_ZERO;
                        end
                    end
                    ialu_pkg::CMD_GCD: begin
                        if (i_stat.a_zero || i_stat.b_zero) begin
                            o_op     = ialu_pkg::DP_CLEAR;
                            n_status = ialu_pkg::ST_GCD_ZERO;
                        end
                    end
                    default: begin
                        o_op     = ialu_pkg::DP_CLEAR;
                        n_status = ialu_pkg::ST_INVALID;
                    end
                endcase
            end
            ialu_pkg::S_MUL:   o_op = ialu_pkg::DP_MUL_STEP;
            ialu_pkg::S_ABS_A: o_op = ialu_pkg::DP_ABS_A;
            ialu_pkg::S_ABS_B: o_op = ialu_pkg::DP_ABS_B;
            ialu_pkg::S_DIV:   o_op = ialu_pkg::DP_DIV_STEP;
            ialu_pkg::S_DIV_END: begin
                // divide: apply the sign; gcd: stop on a zero remainder or rotate
                if (r_cmd != ialu_pkg::CMD_GCD) begin
                    o_op = ialu_pkg::DP_SIGN_FIX;
                end else if (i_stat.rem_zero) begin
                    o_op = ialu_pkg::DP_GCD_DONE;
                end else begin
                    o_op = ialu_pkg::DP_GCD_NEXT;
                end
            end
            default: o_op = ialu_pkg::DP_HOLD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ialu_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cmd    <= n_cmd;
        r_order  <= n_order;
        r_status <= n_status;
    end

    assign o_idle   = (r_state == ialu_pkg::S_IDLE);
    assign o_done   = (r_state == ialu_pkg::S_DONE);
    assign o_order  = r_order;
    assign o_status = r_status;

endmodule

@@ hdl/integer_alu_with_gcd_core.sv @@
// Top level of the integer ALU with GCD: stream ports and output register.
// Instantiates ialu_seq and ialu_dp; depends on ialu_pkg.
//
//  Channel   Dir  tdata (low bit up)              tuser (low bit up)
//  s_axis    in   operand_a, operand_b, zero pad  cmd
//  m_axis    out  result_value, zero pad          order, status
//
// Each gcd remainder step is one full pass of the shift-subtract loop
// through the single shared adder.
// s_axis_tready is high only while the sequencer is idle.
// A finished result waits in the output register; the next item is taken
// while it waits. Reset is synchronous, active low, and clears control only.
module integer_alu_with_gcd_core #(
    parameter  int DATA_WIDTH = ialu_pkg::DATA_WIDTH_DEF,
    localparam int IN_W       = ((2 * DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_W      = ((DATA_WIDTH + 7) / 8) * 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [IN_W-1:0]               s_axis_tdata,  // operand_a, operand_b
    input  logic [ialu_pkg::CMD_W-1:0]    s_axis_tuser,  // cmd
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [OUT_W-1:0]              m_axis_tdata,  // result_value
    output logic [ialu_pkg::ORDER_W+ialu_pkg::STATUS_W-1:0]
                                          m_axis_tuser   // order, status
);

    localparam int W = DATA_WIDTH;

    ialu_pkg::t_dp_op   dp_op;
    ialu_pkg::t_dp_stat dp_stat;
    ialu_pkg::t_order   seq_order;
    ialu_pkg::t_status  seq_status;
    logic [W-1:0]       dp_result;
    logic               seq_idle, seq_done, start, take;

    logic                r_out_valid;
    logic [W-1:0]        r_out_value;
    ialu_pkg::t_order    r_out_order;
    ialu_pkg::t_status   r_out_status;

    assign start = s_axis_tvalid && s_axis_tready;
    assign take  = seq_done && (!r_out_valid || m_axis_tready);

    ialu_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_cmd    (ialu_pkg::t_cmd'(s_axis_tuser)),
        .i_take   (take),
        .i_stat   (dp_stat),
        .o_op     (dp_op),
        .o_idle   (seq_idle),
        .o_done   (seq_done),
        .o_order  (seq_order),
        .o_status (seq_status)
    );

    ialu_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (dp_op),
        .i_a      (s_axis_tdata[W-1:0]),
        .i_b      (s_axis_tdata[2*W-1:W]),
        .o_stat   (dp_stat),
        .o_result (dp_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (take) begin
            r_out_value  <= dp_result;
            r_out_order  <= seq_order;
            r_out_status <= seq_status;
        end
    end

    assign s_axis_tready = seq_idle;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'(r_out_value);
    assign m_axis_tuser  = {r_out_status, r_out_order};

endmodule

@@ hdl/ialu_chk.sv @@
// Port-level checker for integer_alu_with_gcd_core, attached by bind.
// Depends on ialu_pkg.
module ialu_chk #(
    parameter  int DATA_WIDTH = ialu_pkg::DATA_WIDTH_DEF,
    localparam int OUT_W      = ((DATA_WIDTH + 7) / 8) * 8
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [OUT_W-1:0]              m_axis_tdata,
    input logic [ialu_pkg::ORDER_W+ialu_pkg::STATUS_W-1:0] m_axis_tuser
);

    logic [ialu_pkg::ORDER_W-1:0]  order;
    logic [ialu_pkg::STATUS_W-1:0] status;

    assign order  = m_axis_tuser[ialu_pkg::ORDER_W-1:0];
    assign status = m_axis_tuser[ialu_pkg::ORDER_W+ialu_pkg::STATUS_W-1:ialu_pkg::ORDER_W];

    // one item in the sequencer at a time: busy right after a transfer in
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a transfer");

    a_error_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && status != ialu_pkg::ST_OK |-> m_axis_tdata == '0)
        else $error("error result carries a nonzero value");

    a_order_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && order != ialu_pkg::ORD_LESS |->
            status == ialu_pkg::ST_OK && m_axis_tdata == '0)
        else $error("compare order with error status or value");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind integer_alu_with_gcd_core ialu_chk #(
    .DATA_WIDTH (DATA_WIDTH)
) u_ialu_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for integer_alu_with_gcd_core: stream stimulus, local ALU predictor.
// Depends on ialu_pkg and the core RTL; needs no files or arguments.
module tb;

    localparam int DW          = ialu_pkg::DATA_WIDTH_DEF;
    localparam int CW          = ialu_pkg::CMD_W;
    localparam int OW          = ialu_pkg::ORDER_W;
    localparam int SW          = ialu_pkg::STATUS_W;
    localparam int IN_W        = ((2 * DW + 7) / 8) * 8;
    localparam int OUT_W       = ((DW + 7) / 8) * 8;
    localparam int LIMIT_CYCLES = 3_000_000;

    localparam logic [CW-1:0] CMD_BAD_LO = 3'd6;
    localparam logic [CW-1:0] CMD_BAD_HI = 3'd7;

    localparam logic [DW-1:0] MIN_VAL = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] MAX_VAL = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] ALL_ONES = {DW{1'b1}};

    typedef struct {
        logic [DW-1:0]      value;
        ialu_pkg::t_order   order;
        ialu_pkg::t_status  status;
    } t_alu_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;   // operand_a, operand_b
    logic [CW-1:0] s_axis_tuser = '0;     // cmd
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;       // result_value
    logic [OW+SW-1:0] m_axis_tuser;       // order, status

    t_alu_result pending_results[$];
    t_alu_result oldest;
    int err_count = 0;
    int result_count = 0;
    int cycle_count = 0;
    bit calm = 1'b0;
    int hold_req = 0;
    int hold_left = 0;
    int idle_left = 0;

    integer_alu_with_gcd_core #(.DATA_WIDTH(DW)) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    task automatic report_mismatch(string msg);
        $display("mismatch at result %0d: %s", result_count, msg);
        err_count++;
    endtask

    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        report_mismatch($sformatf("timeout, %0d results pending", pending_results.size()));
        $display("FAIL integer_alu_with_gcd_core");
        $finish;
    end

    function automatic t_alu_result predict_alu(logic [CW-1:0] cmd,
                                                logic [DW-1:0] a, logic [DW-1:0] b);
        t_alu_result r;
        logic [DW-1:0] ma, mb, q, rem;
        r.value  = '0;
        r.order  = ialu_pkg::ORD_LESS;
        r.status = ialu_pkg::ST_OK;
        // magnitudes as unsigned patterns; the most negative value maps onto itself
        ma = a[DW-1] ? -a : a;
        mb = b[DW-1] ? -b : b;
        case (cmd)
            ialu_pkg::CMD_ADD: r.value = a + b;
            ialu_pkg::CMD_SUB: r.value = a - b;
            ialu_pkg::CMD_MUL: r.value = a * b;
            ialu_pkg::CMD_DIV: begin
                if (b == '0) begin
                    r.status = ialu_pkg::ST_DIV_ZERO;
                end else begin
                    q = ma / mb;
                    r.value = (a[DW-1] ^ b[DW-1]) ? -q : q;
                end
            end
            ialu_pkg::CMD_CMP: begin
                if ($signed(a) < $signed(b))
                    r.order = ialu_pkg::ORD_LESS;
                else if (a == b)
                    r.order = ialu_pkg::ORD_EQUAL;
                else
                    r.order = ialu_pkg::ORD_GREATER;
            end
            ialu_pkg::CMD_GCD: begin
                if (a == '0 || b == '0) begin
                    r.status = ialu_pkg::ST_GCD_ZERO;
                end else begin
                    while (mb != '0) begin
                        rem = ma % mb;
                        ma = mb;
                        mb = rem;
                    end
                    r.value = ma;
                end
            end
            default: r.status = ialu_pkg::ST_INVALID;
        endcase
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_op(logic [CW-1:0] cmd, logic [DW-1:0] a, logic [DW-1:0] b);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'({b, a});
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(predict_alu(cmd, a, b));
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
    endtask

    function automatic logic [DW-1:0] rand_operand();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 40) - 20;
            1: begin
                case ($urandom_range(0, 4))
                    0: return MIN_VAL;
                    1: return MAX_VAL;
                    2: return ALL_ONES;
                    3: return '0;
                    default: return 1;
                endcase
            end
            // shared power-of-two factors give gcd something to find
            2: return $urandom_range(1, 64) << $urandom_range(0, 24);
            default: return $urandom;
        endcase
    endfunction

    // Receiver: random short stalls, or a long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_left > 0) begin
            idle_left = idle_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            idle_left = $urandom_range(0, 2);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending");
            end else begin
                oldest = pending_results.pop_front();
                // full tdata compare also covers the zero padding
                if (m_axis_tdata !== OUT_W'(oldest.value))
                    report_mismatch($sformatf("value %h, want %h",
                                              m_axis_tdata, oldest.value));
                if (m_axis_tuser[OW-1:0] !== oldest.order)
                    report_mismatch($sformatf("order %0d, want %0d",
                                              m_axis_tuser[OW-1:0], oldest.order));
                if (m_axis_tuser[OW+SW-1:OW] !== oldest.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              m_axis_tuser[OW+SW-1:OW],
                                              oldest.status));
            end
            result_count++;
        end
    end

    task automatic test_directed();
        send_op(ialu_pkg::CMD_ADD, MAX_VAL, 1);
        send_op(ialu_pkg::CMD_ADD, MIN_VAL, MIN_VAL);
        send_op(ialu_pkg::CMD_SUB, MIN_VAL, 1);
        send_op(ialu_pkg::CMD_SUB, '0, MIN_VAL);
        send_op(ialu_pkg::CMD_MUL, MAX_VAL, MAX_VAL);
        send_op(ialu_pkg::CMD_MUL, -3, 7);
        send_op(ialu_pkg::CMD_MUL, 32'h0001_0000, 32'h0001_0000);
        send_op(ialu_pkg::CMD_DIV, 7, -2);
        send_op(ialu_pkg::CMD_DIV, -7, 2);
        send_op(ialu_pkg::CMD_DIV, MIN_VAL, ALL_ONES);
        send_op(ialu_pkg::CMD_DIV, MAX_VAL, MIN_VAL);
        send_op(ialu_pkg::CMD_DIV, 5, '0);
        send_op(ialu_pkg::CMD_CMP, MIN_VAL, MAX_VAL);
        send_op(ialu_pkg::CMD_CMP, ALL_ONES, ALL_ONES);
        send_op(ialu_pkg::CMD_CMP, MAX_VAL, MIN_VAL);
        send_op(ialu_pkg::CMD_GCD, '0, 5);
        send_op(ialu_pkg::CMD_GCD, 5, '0);
        send_op(ialu_pkg::CMD_GCD, MIN_VAL, MIN_VAL);
        send_op(ialu_pkg::CMD_GCD, -12, 18);
        // consecutive Fibonacci numbers: the longest remainder chain
        send_op(ialu_pkg::CMD_GCD, 1836311903, 1134903170);
        send_op(ialu_pkg::CMD_GCD, MAX_VAL, 1);
        send_op(CMD_BAD_LO, MAX_VAL, MIN_VAL);
        send_op(CMD_BAD_HI, ALL_ONES, ALL_ONES);
    endtask

    task automatic test_random(int count);
        repeat (count) send_op(CW'($urandom_range(0, 7)), rand_operand(), rand_operand());
    endtask

    // Hold the output off while items keep coming, so the input stalls.
    task automatic test_backpressure();
        hold_req = 150;
        repeat (12) send_op(CW'($urandom_range(0, 4)), rand_operand(), rand_operand());
        wait_drained();
    endtask

    task automatic test_drain_pause();
        test_random(10);
        wait_drained();
        test_random(10);
        wait_drained();
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_backpressure();
        test_drain_pause();
        test_random(400);
        calm = 1'b1;
        test_random(45);
        wait_drained();
        repeat (40) @(negedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        if (err_count == 0)
            $display("PASS integer_alu_with_gcd_core");
        else
            $display("FAIL integer_alu_with_gcd_core");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/ialu_pkg.sv
hdl/ialu_dp.sv
hdl/ialu_seq.sv
hdl/integer_alu_with_gcd_core.sv
hdl/ialu_chk.sv
tb/sv/tb.sv
